>>> rtl/rational_arithmetic_unit_macros.svh
// Assertion helpers for the rational arithmetic unit.
`ifndef RATIONAL_ARITHMETIC_UNIT_MACROS_SVH
`define RATIONAL_ARITHMETIC_UNIT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define RAU_ASSERT_NOW(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("rational_arithmetic_unit: assertion failed");

// Next-cycle implication, disabled during reset.
`define RAU_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("rational_arithmetic_unit: assertion failed");

`endif

>>> rtl/rau_pkg.sv
// ----------------------------------------------------------------------------
// rau_pkg
// Shared constants and types of the rational arithmetic unit.
// ----------------------------------------------------------------------------
package rau_pkg;

  localparam int PART_WIDTH_DEF = 32;

  typedef logic [2:0] func_t;
  typedef logic [1:0] status_t;

  localparam func_t FN_ADD = 3'd0;
  localparam func_t FN_SUB = 3'd1;
  localparam func_t FN_MUL = 3'd2;
  localparam func_t FN_DIV = 3'd3;

  localparam status_t ST_OK       = 2'd0;
  localparam status_t ST_ZERO_DEN = 2'd1;
  localparam status_t ST_OVERFLOW = 2'd2;

endpackage

>>> rtl/rau_divider.sv
// ----------------------------------------------------------------------------
// rau_divider
// Restoring unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module rau_divider #(
  parameter int W = 66
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         start,
  input  logic [W-1:0] dividend,
  input  logic [W-1:0] divisor,
  output logic         done,
  output logic [W-1:0] quotient
);

  localparam int CW = $clog2(W);

  logic [W-1:0]  quo_r;
  logic [W-1:0]  rem_r;
  logic [CW-1:0] cnt_r;
  logic          run_r;
  logic          done_r;
  logic [W:0]    trial;
  logic [W:0]    diff;
  logic          ge;

  assign trial = {rem_r, quo_r[W-1]};
  assign diff  = trial - {1'b0, divisor};
  assign ge    = (trial >= {1'b0, divisor});

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        run_r <= 1'b1;
      end else if (run_r && (cnt_r == CW'(W - 1))) begin
        run_r  <= 1'b0;
        done_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quo_r <= dividend;
      rem_r <= '0;
      cnt_r <= '0;
    end else if (run_r) begin
      // shift in the next dividend bit, keep the difference when it fits
      rem_r <= ge ? diff[W-1:0] : trial[W-1:0];
      quo_r <= {quo_r[W-2:0], ge};
      cnt_r <= cnt_r + CW'(1);
    end
  end

  assign done     = done_r;
  assign quotient = quo_r;

endmodule

>>> rtl/rational_arithmetic_unit.sv
// ----------------------------------------------------------------------------
// rational_arithmetic_unit
// Add, subtract, multiply, divide or normalize fractions, reduced by GCD.
// ----------------------------------------------------------------------------
// One request at a time: a request is taken when start is high and busy is
// low, and busy stays high until out_valid pulses for one cycle with the
// reduced result; the receiver cannot stall. With M = PART_WIDTH+1 and
// W = 2*PART_WIDTH+2, the steps are three shift-add multiplies of M-bit
// parts (a load state, then the add states), one sum state, a binary GCD on
// W-bit values, then two restoring divides. A zero denominator or a zero
// numerator returns right after the sum state.
// ----------------------------------------------------------------------------
`include "rational_arithmetic_unit_macros.svh"

module rational_arithmetic_unit #(
  parameter int PART_WIDTH = rau_pkg::PART_WIDTH_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  start,
  output logic                  busy,
  input  logic [2:0]            in_func,
  input  logic signed [31:0]    in_left_num,
  input  logic signed [31:0]    in_left_den,
  input  logic signed [31:0]    in_right_num,
  input  logic signed [31:0]    in_right_den,
  output logic                  out_valid,
  output logic signed [31:0]    out_result_num,
  output logic [30:0]           out_result_den,
  output logic [1:0]            out_status
);

  localparam int M  = PART_WIDTH + 1;
  localparam int W  = 2 * PART_WIDTH + 2;
  localparam int MC = $clog2(M);
  localparam int KW = $clog2(W + 1);

  typedef enum logic [2:0] {
    S_IDLE, S_LOAD, S_MUL, S_SUM, S_GCD, S_DIVN, S_DIVD
  } state_t;

  typedef struct packed {
    logic         neg;
    logic [M-1:0] mag;
  } smag_t;

  function automatic smag_t take_part(input logic [31:0] raw);
    smag_t r;
    r.neg = raw[PART_WIDTH-1];
    r.mag = r.neg ? ({1'b1, {PART_WIDTH{1'b0}}} - {1'b0, raw[PART_WIDTH-1:0]})
                  : {1'b0, raw[PART_WIDTH-1:0]};
    return r;
  endfunction

  state_t          state_r;
  logic            busy_r;
  logic            out_valid_r;
  logic [31:0]     res_num_r;
  logic [30:0]     res_den_r;
  rau_pkg::status_t status_r;

  rau_pkg::func_t  func_r;
  smag_t           ln_r, ld_r, rn_r, rd_r;
  logic [1:0]      mi_r;
  logic [W-1:0]    mcand_r;
  logic [M-1:0]    mplier_r;
  logic [W-1:0]    acc_r;
  logic [MC-1:0]   mcnt_r;
  logic            sgn_r;
  logic [W-1:0]    p0_r, p1_r, p2_r;
  logic            p0n_r, p1n_r, p2n_r;
  logic [W-1:0]    num_r, den_r;
  logic            numn_r, denn_r;
  logic [W-1:0]    ga_r, gb_r;
  logic [KW-1:0]   k_r;
  logic [W-1:0]    g_r;
  logic [W-1:0]    nm_r;
  logic            div_start_r;

  smag_t           sel_a, sel_b;
  logic [W-1:0]    acc_nxt;
  logic [W-1:0]    sum_mag;
  logic            sum_neg;
  logic            div_done;
  logic [W-1:0]    div_quo;
  logic [W-1:0]    limit;
  logic            neg;
  logic            ovf;
  logic [W+31:0]   nm_ext, dm_ext;
  logic [31:0]     nm32;

  // operand pairs for the three products of each operation
  always_comb begin
    sel_a = '0;
    sel_b = '0;
    case (func_r)
      rau_pkg::FN_ADD, rau_pkg::FN_SUB: begin
        case (mi_r)
          2'd0: begin sel_a = ln_r; sel_b = rd_r; end
          2'd1: begin
            sel_a = rn_r;
            if (func_r == rau_pkg::FN_SUB) sel_a.neg = !rn_r.neg && (rn_r.mag != '0);
            sel_b = ld_r;
          end
          default: begin sel_a = ld_r; sel_b = rd_r; end
        endcase
      end
      rau_pkg::FN_MUL: begin
        case (mi_r)
          2'd0:    begin sel_a = ln_r; sel_b = rn_r; end
          2'd1:    begin sel_a = '0;   sel_b = '0;   end
          default: begin sel_a = ld_r; sel_b = rd_r; end
        endcase
      end
      rau_pkg::FN_DIV: begin
        case (mi_r)
          2'd0:    begin sel_a = ln_r; sel_b = rd_r; end
          2'd1:    begin sel_a = '0;   sel_b = '0;   end
          default: begin sel_a = ld_r; sel_b = rn_r; end
        endcase
      end
      default: begin
        sel_b.mag = M'(1);
        case (mi_r)
          2'd0:    sel_a = ln_r;
          2'd1:    begin sel_a = '0; sel_b = '0; end
          default: sel_a = ld_r;
        endcase
      end
    endcase
  end

  assign acc_nxt = mplier_r[0] ? (acc_r + mcand_r) : acc_r;

  // signed-magnitude add of the two numerator products
  always_comb begin
    if (p0n_r == p1n_r) begin
      sum_mag = p0_r + p1_r;
      sum_neg = p0n_r;
    end else if (p0_r >= p1_r) begin
      sum_mag = p0_r - p1_r;
      sum_neg = p0n_r;
    end else begin
      sum_mag = p1_r - p0_r;
      sum_neg = p1n_r;
    end
    if (sum_mag == '0) sum_neg = 1'b0;
  end

  rau_divider #(.W(W)) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start_r),
    .dividend ((state_r == S_DIVD) ? den_r : num_r),
    .divisor  (g_r),
    .done     (div_done),
    .quotient (div_quo)
  );

  assign limit  = W'(1) << (PART_WIDTH - 1);
  assign neg    = numn_r ^ denn_r;
  assign ovf    = (div_quo > limit - W'(1)) ||
                  (neg ? (nm_r > limit) : (nm_r > limit - W'(1)));
  assign nm_ext = {32'd0, nm_r};
  assign dm_ext = {32'd0, div_quo};
  assign nm32   = nm_ext[31:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      busy_r      <= 1'b0;
      out_valid_r <= 1'b0;
      div_start_r <= 1'b0;
    end else begin
      out_valid_r <= 1'b0;
      div_start_r <= 1'b0;
      case (state_r)
        S_IDLE: begin
          if (start) begin
            func_r  <= in_func;
            ln_r    <= take_part(in_left_num);
            ld_r    <= take_part(in_left_den);
            rn_r    <= take_part(in_right_num);
            rd_r    <= take_part(in_right_den);
            mi_r    <= 2'd0;
            busy_r  <= 1'b1;
            state_r <= S_LOAD;
          end
        end
        S_LOAD: begin
          mcand_r  <= {{(W-M){1'b0}}, sel_a.mag};
          mplier_r <= sel_b.mag;
          sgn_r    <= sel_a.neg ^ sel_b.neg;
          acc_r    <= '0;
          mcnt_r   <= '0;
          state_r  <= S_MUL;
        end
        S_MUL: begin
          acc_r    <= acc_nxt;
          mcand_r  <= mcand_r << 1;
          mplier_r <= mplier_r >> 1;
          mcnt_r   <= mcnt_r + MC'(1);
          if (mcnt_r == MC'(M - 1)) begin
            case (mi_r)
              2'd0:    begin p0_r <= acc_nxt; p0n_r <= sgn_r; end
              2'd1:    begin p1_r <= acc_nxt; p1n_r <= sgn_r; end
              default: begin p2_r <= acc_nxt; p2n_r <= sgn_r; end
            endcase
            mi_r    <= mi_r + 2'd1;
            state_r <= (mi_r == 2'd2) ? S_SUM : S_LOAD;
          end
        end
        S_SUM: begin
          num_r  <= sum_mag;
          numn_r <= sum_neg;
          den_r  <= p2_r;
          denn_r <= p2n_r;
          ga_r   <= sum_mag;
          gb_r   <= p2_r;
          k_r    <= '0;
          if (p2_r == '0) begin
            res_num_r   <= '0;
            res_den_r   <= '0;
            status_r    <= rau_pkg::ST_ZERO_DEN;
            out_valid_r <= 1'b1;
            busy_r      <= 1'b0;
            state_r     <= S_IDLE;
          end else if (sum_mag == '0) begin
            res_num_r   <= '0;
            res_den_r   <= 31'd1;
            status_r    <= rau_pkg::ST_OK;
            out_valid_r <= 1'b1;
            busy_r      <= 1'b0;
            state_r     <= S_IDLE;
          end else begin
            state_r <= S_GCD;
          end
        end
        S_GCD: begin
          // binary GCD: one shift or one subtract per cycle
          if (ga_r == '0 || gb_r == '0) begin
            g_r         <= ((ga_r == '0) ? gb_r : ga_r) << k_r;
            div_start_r <= 1'b1;
            state_r     <= S_DIVN;
          end else if (!ga_r[0] && !gb_r[0]) begin
            ga_r <= ga_r >> 1;
            gb_r <= gb_r >> 1;
            k_r  <= k_r + KW'(1);
          end else if (!ga_r[0]) begin
            ga_r <= ga_r >> 1;
          end else if (!gb_r[0]) begin
            gb_r <= gb_r >> 1;
          end else if (ga_r >= gb_r) begin
            ga_r <= ga_r - gb_r;
          end else begin
            gb_r <= gb_r - ga_r;
          end
        end
        S_DIVN: begin
          if (div_done) begin
            nm_r        <= div_quo;
            div_start_r <= 1'b1;
            state_r     <= S_DIVD;
          end
        end
        S_DIVD: begin
          if (div_done) begin
            if (ovf) begin
              res_num_r <= '0;
              res_den_r <= '0;
              status_r  <= rau_pkg::ST_OVERFLOW;
            end else begin
              res_num_r <= neg ? (32'd0 - nm32) : nm32;
              res_den_r <= dm_ext[30:0];
              status_r  <= rau_pkg::ST_OK;
            end
            out_valid_r <= 1'b1;
            busy_r      <= 1'b0;
            state_r     <= S_IDLE;
          end
        end
        default: begin
          busy_r  <= 1'b0;
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  assign busy           = busy_r;
  assign out_valid      = out_valid_r;
  assign out_result_num = res_num_r;
  assign out_result_den = res_den_r;
  assign out_status     = status_r;

  `RAU_ASSERT_NOW(a_fail_zeroed, clk, rst_n, out_valid && out_status != rau_pkg::ST_OK, out_result_num == 32'd0 && out_result_den == 31'd0)
  `RAU_ASSERT_NOW(a_ok_den_pos, clk, rst_n, out_valid && out_status == rau_pkg::ST_OK, out_result_den != 31'd0)
  `RAU_ASSERT_NOW(a_done_idle, clk, rst_n, out_valid, !busy)
  `RAU_ASSERT_NEXT(a_take_busy, clk, rst_n, start && !busy, busy)

endmodule

>>> sim/rational_arithmetic_unit_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rational_arithmetic_unit_checker
// Watches accepted requests and result words of the fraction unit, predicts
// each reduced fraction and its status, and compares field by field.
// ----------------------------------------------------------------------------
module rational_arithmetic_unit_checker (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  logic               busy,
  input  logic [2:0]         in_func,
  input  logic signed [31:0] in_left_num,
  input  logic signed [31:0] in_left_den,
  input  logic signed [31:0] in_right_num,
  input  logic signed [31:0] in_right_den,
  input  logic               out_valid,
  input  logic signed [31:0] out_result_num,
  input  logic [30:0]        out_result_den,
  input  logic [1:0]         out_status,
  output int                 fail_count,
  output int                 pending,
  output int                 result_count
);

  typedef struct packed {
    logic [31:0]      num;
    logic [30:0]      den;
    rau_pkg::status_t status;
  } fraction_t;

  typedef struct packed {
    logic        neg;
    logic [63:0] mag;
  } signed_mag_t;

  fraction_t expected_fractions[$];

  function automatic signed_mag_t to_sm(logic [31:0] v);
    signed_mag_t r;
    r.neg = v[31];
    r.mag = v[31] ? 64'(-{32'b0, v} & 64'hFFFF_FFFF) : {32'b0, v};
    return r;
  endfunction

  function automatic signed_mag_t sm_mul(signed_mag_t a, signed_mag_t b);
    signed_mag_t r;
    r.mag = a.mag * b.mag;
    r.neg = (a.neg != b.neg) && (r.mag != 0);
    return r;
  endfunction

  function automatic signed_mag_t sm_add(signed_mag_t a, signed_mag_t b);
    signed_mag_t r;
    if (a.neg == b.neg) begin
      r.mag = a.mag + b.mag;
      r.neg = a.neg;
    end else if (a.mag >= b.mag) begin
      r.mag = a.mag - b.mag;
      r.neg = a.neg;
    end else begin
      r.mag = b.mag - a.mag;
      r.neg = b.neg;
    end
    if (r.mag == 0) r.neg = 1'b0;
    return r;
  endfunction

  function automatic fraction_t reduce_fraction(logic [2:0] fn, logic [31:0] lnum,
                                                logic [31:0] lden, logic [31:0] rnum,
                                                logic [31:0] rden);
    signed_mag_t ln, ld, rn, rd, num, den;
    fraction_t   f;
    logic [63:0] a, b, t, nm, dm;
    logic        neg;
    ln = to_sm(lnum);
    ld = to_sm(lden);
    rn = to_sm(rnum);
    rd = to_sm(rden);
    f = '0;
    case (fn)
      rau_pkg::FN_ADD, rau_pkg::FN_SUB: begin
        if (fn == rau_pkg::FN_SUB) rn.neg = !rn.neg && (rn.mag != 0);
        num = sm_add(sm_mul(ln, rd), sm_mul(rn, ld));
        den = sm_mul(ld, rd);
      end
      rau_pkg::FN_MUL: begin
        num = sm_mul(ln, rn);
        den = sm_mul(ld, rd);
      end
      rau_pkg::FN_DIV: begin
        num = sm_mul(ln, rd);
        den = sm_mul(ld, rn);
      end
      default: begin
        num = ln;
        den = ld;
      end
    endcase
    if (den.mag == 0) begin
      f.status = rau_pkg::ST_ZERO_DEN;
    end else if (num.mag == 0) begin
      f.den = 31'd1;
      f.status = rau_pkg::ST_OK;
    end else begin
      neg = num.neg != den.neg;
      a = num.mag;
      b = den.mag;
      while (b != 0) begin
        t = a % b;
        a = b;
        b = t;
      end
      nm = num.mag / a;
      dm = den.mag / a;
      if (dm > 64'h7FFF_FFFF || (neg ? nm > 64'h8000_0000 : nm > 64'h7FFF_FFFF)) begin
        f.status = rau_pkg::ST_OVERFLOW;
      end else begin
        f.num = neg ? 32'(-nm) : nm[31:0];
        f.den = dm[30:0];
        f.status = rau_pkg::ST_OK;
      end
    end
    return f;
  endfunction

  always @(posedge clk) begin
    fraction_t exp_f;
    if (!rst_n) begin
      fail_count <= 0;
      result_count <= 0;
      expected_fractions.delete();
    end else begin
      if (start && !busy)
        expected_fractions.push_back(reduce_fraction(in_func, in_left_num, in_left_den,
                                                     in_right_num, in_right_den));
      if (out_valid) begin
        result_count <= result_count + 1;
        if (expected_fractions.size() == 0) begin
          $error("result word with no request waiting");
          fail_count <= fail_count + 1;
        end else begin
          exp_f = expected_fractions.pop_front();
          if (out_result_num !== exp_f.num || out_result_den !== exp_f.den ||
              out_status !== exp_f.status) begin
            fail_count <= fail_count + 1;
            if (out_result_num !== exp_f.num)
              $error("result_num expected %0d actual %0d", $signed(exp_f.num), out_result_num);
            if (out_result_den !== exp_f.den)
              $error("result_den expected %0d actual %0d", exp_f.den, out_result_den);
            if (out_status !== exp_f.status)
              $error("status expected %0d actual %0d", exp_f.status, out_status);
          end
        end
      end
    end
  end

  assign pending = expected_fractions.size();

endmodule

>>> sim/rational_arithmetic_unit_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rational_arithmetic_unit_tb
// Drives directed and random fraction requests with random gaps and reports
// the verdict from the checker's failure and pending counts.
// ----------------------------------------------------------------------------
module rational_arithmetic_unit_tb;

  localparam rau_pkg::func_t FN_NORM = 3'd4;

  logic               clk;
  logic               rst_n;
  logic               start;
  logic               busy;
  logic [2:0]         in_func;
  logic signed [31:0] in_left_num, in_left_den, in_right_num, in_right_den;
  logic               out_valid;
  logic signed [31:0] out_result_num;
  logic [30:0]        out_result_den;
  logic [1:0]         out_status;
  int                 fail_count, pending, result_count;
  int                 request_count;

  rational_arithmetic_unit i_dut (
    .clk, .rst_n, .start, .busy, .in_func, .in_left_num, .in_left_den,
    .in_right_num, .in_right_den, .out_valid, .out_result_num, .out_result_den,
    .out_status
  );

  rational_arithmetic_unit_checker i_checker (
    .clk, .rst_n, .start, .busy, .in_func, .in_left_num, .in_left_den,
    .in_right_num, .in_right_den, .out_valid, .out_result_num, .out_result_den,
    .out_status, .fail_count, .pending, .result_count
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Pick a part: extremes, small values, or fully random bits.
  function automatic logic [31:0] pick_part();
    case ($urandom_range(0, 9))
      0: return 32'h8000_0000;
      1: return 32'h7FFF_FFFF;
      2: return 32'h0;
      3: return 32'($signed($urandom_range(0, 20)) - 10);
      4, 5: return 32'($signed($urandom_range(0, 2000)) - 1000);
      6: return 32'($signed($urandom_range(0, 131072)) - 65536);
      default: return $urandom();
    endcase
  endfunction

  task automatic send_request(logic [2:0] fn, logic [31:0] ln, logic [31:0] ld,
                              logic [31:0] rn, logic [31:0] rd);
    start        <= 1'b1;
    in_func      <= fn;
    in_left_num  <= ln;
    in_left_den  <= ld;
    in_right_num <= rn;
    in_right_den <= rd;
    @(posedge clk);
    while (busy) @(posedge clk);
    start <= 1'b0;
    request_count++;
    // drop start before the next word
    @(posedge clk);
  endtask

  task automatic idle_gap();
    int n;
    n = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 14);
    repeat (n) @(posedge clk);
  endtask

  initial begin
    int i;
    logic [2:0] fn;
    request_count = 0;
    rst_n <= 1'b0;
    start <= 1'b0;
    in_func <= '0;
    in_left_num <= '0;
    in_left_den <= 32'd1;
    in_right_num <= '0;
    in_right_den <= 32'd1;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: every operation, extremes, zero denominators, overflow.
    send_request(rau_pkg::FN_ADD, 32'd1, 32'd2, 32'd1, 32'd3);
    send_request(rau_pkg::FN_SUB, 32'd1, 32'd2, 32'd1, 32'd2);
    send_request(rau_pkg::FN_MUL, -32'sd3, 32'd4, 32'd8, 32'd9);
    send_request(rau_pkg::FN_DIV, 32'd2, 32'd3, -32'sd4, 32'd5);
    send_request(FN_NORM, 32'd6, -32'sd4, 32'd0, 32'd0);
    send_request(FN_NORM, 32'd0, -32'sd7, 32'd5, 32'd5);
    send_request(FN_NORM, 32'd0, 32'd0, 32'd1, 32'd1);
    send_request(rau_pkg::FN_ADD, 32'd1, 32'd0, 32'd1, 32'd1);
    send_request(rau_pkg::FN_DIV, 32'd1, 32'd1, 32'd0, 32'd1);
    send_request(rau_pkg::FN_DIV, 32'd0, 32'd1, 32'd0, 32'd1);
    send_request(FN_NORM, 32'h8000_0000, 32'd1, 32'd0, 32'd0);
    send_request(FN_NORM, 32'h8000_0000, -32'sd1, 32'd0, 32'd0);
    send_request(FN_NORM, 32'd1, 32'h8000_0000, 32'd0, 32'd0);
    send_request(FN_NORM, -32'sd2, 32'h8000_0000, 32'd0, 32'd0);
    send_request(rau_pkg::FN_MUL, 32'h7FFF_FFFF, 32'd1, 32'h7FFF_FFFF, 32'd1);
    send_request(rau_pkg::FN_ADD, 32'h7FFF_FFFF, 32'd1, 32'h7FFF_FFFF, 32'd1);
    send_request(rau_pkg::FN_SUB, 32'h8000_0000, 32'd1, 32'd1, 32'd1);
    send_request(rau_pkg::FN_MUL, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                 32'h8000_0000);
    send_request(rau_pkg::FN_DIV, 32'hFFFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000,
                 32'hFFFF_FFFF);
    send_request(3'd5, 32'd10, 32'd4, 32'd1, 32'd1);
    send_request(3'd6, -32'sd10, 32'd4, 32'd1, 32'd1);
    send_request(3'd7, 32'd9, -32'sd3, 32'd1, 32'd1);

    // Hold until the unit has drained.
    while (pending != 0) @(posedge clk);

    for (i = 0; i < 1830; i++) begin
      idle_gap();
      fn = ($urandom_range(0, 9) == 0) ? 3'($urandom_range(4, 7)) : 3'($urandom_range(0, 3));
      send_request(fn, pick_part(), pick_part(), pick_part(), pick_part());
    end

    while (pending != 0) @(posedge clk);
    repeat (600) @(posedge clk);
    $display("Sent %0d requests over all operation codes, checked %0d result words.",
             request_count, result_count);
    if (fail_count == 0 && pending == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  initial begin
    #10_000_000;
    $display("tb: failure");
    $finish;
  end

endmodule

>>> filelist.f
+incdir+rtl
rtl/rau_pkg.sv
rtl/rau_divider.sv
rtl/rational_arithmetic_unit.sv
sim/rational_arithmetic_unit_checker.sv
sim/rational_arithmetic_unit_tb.sv
